[rtl/isst_pkg.sv]
// Shared types and constants for the interpolation search table.
// Depends on nothing; every other file imports it.
package isst_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = 10;
  localparam int PosW       = 11;
  localparam int KeyW       = 64;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int ProdW      = KeyW + IdxW;
  localparam int DivCntW    = 7;

  localparam logic [KeyW-1:0] SignBias = {1'b1, {(KeyW-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_EXACT = 2'd1,
    REQ_LOWER = 2'd2,
    REQ_UPPER = 2'd3
  } req_kind_e;

  // Queued request; the key is stored sign-flipped so unsigned order is signed order.
  typedef struct packed {
    req_kind_e       kind;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
  } isst_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOP,
    S_RD_HI,
    S_CHK,
    S_MUL,
    S_DIV,
    S_PROBE,
    S_CMP,
    S_OUT
  } eng_state_e;

endpackage

[rtl/isst_req_if.sv]
// Request and result channel interfaces for the search table.
// Depends on isst_pkg for the field widths.
interface isst_req_if import isst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [IdxW-1:0]        entry_index;
  logic signed [KeyW-1:0] item_value;

  modport source (output valid, req_type, entry_index, item_value, input ready);
  modport sink   (input valid, req_type, entry_index, item_value, output ready);
endinterface

interface isst_rsp_if import isst_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [PosW-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

[rtl/interpolation_search_sorted_table_top.sv]
// Timing: a load request is written to the table as the engine takes it from the queue,
// once the engine is idle. A query passes through the queue, then runs interpolation steps
// (range check, multiply, bit-serial divide, read and compare) and midpoint or equal-ends
// steps (range check, read and compare), then the last range test and the output
// register; the step count depends on the data. One request is worked on at a time; a
// 4-entry queue keeps accepting meanwhile. Reset clears control state and the entry
// count; table contents are undefined until loaded, and there is no clearing pass.
module interpolation_search_sorted_table_top import isst_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [PosW-1:0] cfg_wdata_i,
  isst_req_if.sink        req_i,
  isst_rsp_if.source      rsp_o
);

  // Number of valid entries, as written by software.
  logic [PosW-1:0] entries_q;
  // Effective count, saturated to the table depth.
  logic [PosW-1:0] count;
  logic            item_valid, item_ready;
  isst_item_t      item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  assign count = (entries_q > PosW'(TableDepth)) ? PosW'(TableDepth) : entries_q;

  // The front end only queues requests, so the engine can stall on the result
  // side without blocking new requests until the queue fills.
  isst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // The engine holds the table, runs loads and searches in order, and keeps
  // its result in an output register.
  isst_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .count_i      (count),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .rsp          (rsp_o)
  );

endmodule

[rtl/isst_front.sv]
// Front end: takes requests, classifies them and holds them in a short queue.
// Depends on isst_pkg and isst_req_if.
module isst_front import isst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  isst_req_if.sink   req,
  output logic       item_valid_o,
  input  logic       item_ready_i,
  output isst_item_t item_o
);

  isst_item_t            queue_q [QueueDepth];
  logic [QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]        count_q, count_d;
  logic                  push, pop;
  isst_item_t            new_item;

  assign req.ready    = (count_q != QueueDepth[QPtrW:0]);
  assign push         = req.valid && req.ready;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    new_item.kind = req_kind_e'(req.req_type);
    new_item.idx  = req.entry_index;
    new_item.key  = req.item_value ^ SignBias;
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= QueueDepth[QPtrW:0])
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("push lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q == '0) |-> !pop)
    else $error("pop from empty queue");

endmodule

[rtl/isst_engine.sv]
// Back end: table memory, probe sequencer and bit-serial scaled divider.
// Depends on isst_pkg and isst_rsp_if.
module isst_engine import isst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [PosW-1:0] count_i,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  isst_item_t  item_i,
  isst_rsp_if.source  rsp
);

  logic [KeyW-1:0] mem [TableDepth];
  logic [KeyW-1:0] rdata_q;
  logic [IdxW-1:0] raddr;
  logic            we;

  eng_state_e       state_q, state_d;
  req_kind_e        kind_q, kind_d;
  logic [KeyW-1:0]  key_q, key_d, lo_q, lo_d, num_q, num_d, den_q, den_d, rem_q, rem_d;
  logic [PosW-1:0]  low_q, low_d, high_q, high_d, p_q, p_d, quo_q, quo_d;
  logic [IdxW-1:0]  span_q, span_d;
  logic [ProdW-1:0] div_q, div_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic             res_found_q, res_found_d;
  logic [PosW-1:0]  res_pos_q, res_pos_d;
  logic             out_valid_q, out_found_q;
  logic [PosW-1:0]  out_pos_q;
  logic             out_load;

  logic [PosW-1:0]  hidx, span_w, mid, off;
  logic [KeyW:0]    r_sh;
  logic             in_range, is_exact, go_right;

  assign is_exact     = (kind_q == REQ_EXACT);
  assign item_ready_o = (state_q == S_IDLE);
  assign we           = (state_q == S_IDLE) && item_valid_i && (item_i.kind == REQ_LOAD);
  assign out_load     = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

  assign rsp.valid    = out_valid_q;
  assign rsp.found    = out_found_q;
  assign rsp.position = out_pos_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[item_i.idx] <= item_i.key;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    hidx     = is_exact ? high_q : high_q - 1'b1;
    span_w   = hidx - low_q;
    mid      = low_q + ((high_q - low_q) >> 1);
    in_range = (key_q >= lo_q) && (key_q <= rdata_q);
    go_right = (kind_q == REQ_UPPER) ? (rdata_q <= key_q) : (rdata_q < key_q);
    r_sh     = {rem_q, div_q[ProdW-1]};
    off      = '0;

    raddr = low_q[IdxW-1:0];
    case (state_q)
      S_RD_HI: raddr = hidx[IdxW-1:0];
      S_PROBE: raddr = p_q[IdxW-1:0];
      default: raddr = low_q[IdxW-1:0];
    endcase

    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    lo_d        = lo_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    low_d       = low_q;
    high_d      = high_q;
    p_d         = p_q;
    quo_d       = quo_q;
    span_d      = span_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i && item_i.kind != REQ_LOAD) begin
          kind_d = item_i.kind;
          key_d  = item_i.key;
          low_d  = '0;
          if (count_i == '0) begin
            res_found_d = (item_i.kind != REQ_EXACT);
            res_pos_d   = '0;
            state_d     = S_OUT;
          end else begin
            high_d  = (item_i.kind == REQ_EXACT) ? count_i - 1'b1 : count_i;
            state_d = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (is_exact && low_q > high_q) begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = S_OUT;
        end else if (!is_exact && low_q >= high_q) begin
          res_found_d = 1'b1;
          res_pos_d   = low_q;
          state_d     = S_OUT;
        end else begin
          state_d = S_RD_HI;
        end
      end
      S_RD_HI: begin
        lo_d    = rdata_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!in_range) begin
          if (is_exact) begin
            res_found_d = 1'b0;
            res_pos_d   = '0;
            state_d     = S_OUT;
          end else begin
            p_d     = mid;
            state_d = S_PROBE;
          end
        end else if (rdata_q == lo_q) begin
          p_d     = low_q;
          state_d = S_PROBE;
        end else begin
          num_d   = key_q - lo_q;
          den_d   = rdata_q - lo_q;
          span_d  = span_w[IdxW-1:0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        div_d   = {{IdxW{1'b0}}, num_q} * {{KeyW{1'b0}}, span_q};
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = DivCntW'(ProdW - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        div_d = {div_q[ProdW-2:0], 1'b0};
        if (r_sh >= {1'b0, den_q}) begin
          rem_d = KeyW'(r_sh - {1'b0, den_q});
          quo_d = {quo_q[PosW-2:0], 1'b1};
        end else begin
          rem_d = r_sh[KeyW-1:0];
          quo_d = {quo_q[PosW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          off     = (quo_d > {1'b0, span_q}) ? {1'b0, span_q} : quo_d;
          p_d     = low_q + off;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_LOOP;
        if (is_exact) begin
          if (rdata_q == key_q) begin
            res_found_d = 1'b1;
            res_pos_d   = p_q;
            state_d     = S_OUT;
          end else if (rdata_q < key_q) begin
            low_d = p_q + 1'b1;
          end else if (p_q == '0) begin
            res_found_d = 1'b0;
            res_pos_d   = '0;
            state_d     = S_OUT;
          end else begin
            high_d = p_q - 1'b1;
          end
        end else if (go_right) begin
          low_d = p_q + 1'b1;
        end else begin
          high_d = p_q;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    lo_q        <= lo_d;
    num_q       <= num_d;
    den_q       <= den_d;
    rem_q       <= rem_d;
    low_q       <= low_d;
    high_q      <= high_d;
    p_q         <= p_d;
    quo_q       <= quo_d;
    span_q      <= span_d;
    div_q       <= div_d;
    cnt_q       <= cnt_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_PROBE) |-> (p_q >= low_q && p_q <= high_q))
    else $error("probe outside current range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_DIV) |=> (state_q == S_DIV || state_q == S_PROBE))
    else $error("divider left early");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_load && !res_found_q) |-> (res_pos_q == '0))
    else $error("miss with nonzero position");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_load && kind_q != REQ_EXACT) |-> res_found_q)
    else $error("bound result without found");

endmodule
